// ===== hw/rtl/rbmi_pkg.sv =====
// Shared types, codes and helpers for the rigid body midpoint integrator.
`default_nettype none
package rbmi_pkg;

    // item mode codes
    typedef enum logic [2:0] {
        MODE_FORCE   = 3'd0,
        MODE_IMPULSE = 3'd1,
        MODE_TICK    = 3'd2,
        MODE_SET_POS = 3'd3,
        MODE_SET_VEL = 3'd4
    } mode_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,   // a  = F * dt
        ST_MUL_B,   // b  = a * inv_mass
        ST_MUL_C,   // c  = I * inv_mass, then dv = b + c
        ST_AVG,     // avg = v + dv/2
        ST_MUL_D,   // dx = avg * dt, then pos/vel update
        ST_DONE
    } state_t;

    // cycles from operand select to rounded product at the multiplier output
    localparam logic [1:0] MUL_LAT = 2'd2;

    localparam logic signed [31:0] Q16_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q16_MIN = 32'sh8000_0000;

    function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
            sat_add32 = s[32] ? Q16_MIN : Q16_MAX;
        else
            sat_add32 = s[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rbmi_mul.sv =====
// Shared signed-by-unsigned Q16.16 multiplier with round and saturate, two stages.
`default_nettype none
module rbmi_mul
    import rbmi_pkg::*;
(
    input  wire logic               clk,
    input  wire logic signed [31:0] op_a,
    input  wire logic        [31:0] op_b,
    output logic signed [31:0]      result
);

    logic signed [65:0] prod_reg;
    logic signed [65:0] prod_next;
    logic signed [65:0] rnd;
    logic signed [49:0] shr;
    logic signed [31:0] result_reg;
    logic signed [31:0] result_next;

    assign prod_next = $signed({{33{op_a[31]}}, op_a}) * $signed({34'd0, op_b});

    // round to nearest, ties upward, then clamp
    assign rnd = prod_reg + 66'sd32768;
    assign shr = rnd[65:16];

    always_comb
    begin
        if (shr > $signed({{18{1'b0}}, Q16_MAX}))
            result_next = Q16_MAX;
        else if (shr < $signed({{18{1'b1}}, Q16_MIN}))
            result_next = Q16_MIN;
        else
            result_next = shr[31:0];
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/rigid_body_midpoint_integrator_unit.sv =====
// Top level: state, sequencer and output register of the midpoint integrator.
`default_nettype none
// Point-mass integrator for one 2D body in signed Q16.16. Each accepted item
// (add force, add impulse, tick, set position, set velocity) yields one
// result item with the position and velocity after it. Items are taken one
// at a time: in_stall is high from acceptance until the result is loaded
// into the output register. Non-tick items, and ticks with a zero step, go
// straight to the result load; out_valid rises as the input becomes free
// again. A tick first runs, for each axis in turn (x, then y), four products
// through one shared two-stage multiplier, with a half-step average between
// the third and fourth, and then loads the result.
// A held result does not block the next acceptance; the sequencer only
// waits in its last step if the previous result has not been taken.
// inverse_mass is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
// It resets to 1.0, and zero means infinite mass (forces are dropped).
module rigid_body_midpoint_integrator_unit
    import rbmi_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration
    input  wire logic               cfg_we,
    input  wire logic        [31:0] cfg_wdata,
    // input channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic        [2:0]  mode,
    input  wire logic signed [31:0] vec_x,
    input  wire logic signed [31:0] vec_y,
    input  wire logic        [23:0] step_time,
    // output channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      pos_x_out,
    output logic signed [31:0]      pos_y_out,
    output logic signed [31:0]      vel_x_out,
    output logic signed [31:0]      vel_y_out
);

    state_t state_reg, state_next;

    logic        [31:0] inv_mass_reg;
    logic signed [31:0] pos_reg   [2];
    logic signed [31:0] vel_reg   [2];
    logic signed [31:0] force_reg [2];
    logic signed [31:0] imp_reg   [2];

    logic        [23:0] dt_reg;
    logic               axis_reg;     // 0 = x, 1 = y
    logic        [1:0]  cnt_reg;
    logic signed [31:0] tmp_reg;      // a, then b, then avg
    logic signed [31:0] dv_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_px_reg, out_py_reg, out_vx_reg, out_vy_reg;

    logic signed [31:0] mul_a;
    logic        [31:0] mul_b;
    logic signed [31:0] mul_res;
    logic               in_take;
    logic               mul_done;
    logic               out_free;
    logic               load_out;
    logic               tick_go;

    rbmi_mul u_mul (
        .clk    (clk),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .result (mul_res)
    );

    assign in_take  = in_valid && !in_stall;
    assign mul_done = (cnt_reg == MUL_LAT);
    assign out_free = !out_valid_reg || !out_stall;
    assign tick_go  = (mode == MODE_TICK) && (step_time != 24'd0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = tick_go ? ST_MUL_A : ST_DONE;
            end
            ST_MUL_A:
            begin
                if (mul_done)
                    state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                if (mul_done)
                    state_next = ST_MUL_C;
            end
            ST_MUL_C:
            begin
                if (mul_done)
                    state_next = ST_AVG;
            end
            ST_AVG:
                state_next = ST_MUL_D;
            ST_MUL_D:
            begin
                if (mul_done)
                    state_next = axis_reg ? ST_DONE : ST_MUL_A;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control outputs and multiplier operand select
    always_comb
    begin
        in_stall = 1'b1;
        load_out = 1'b0;
        mul_a    = tmp_reg;
        mul_b    = {8'd0, dt_reg};
        case (state_reg)
            ST_IDLE:
                in_stall = 1'b0;
            ST_MUL_A:
                mul_a = force_reg[axis_reg];
            ST_MUL_B:
                mul_b = inv_mass_reg;
            ST_MUL_C:
            begin
                mul_a = imp_reg[axis_reg];
                mul_b = inv_mass_reg;
            end
            ST_DONE:
                load_out = out_free;
            default:
            begin
                mul_a = tmp_reg;
                mul_b = {8'd0, dt_reg};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 2'd0;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            inv_mass_reg  <= 32'h0001_0000;
            for (int i = 0; i < 2; i++)
            begin
                pos_reg[i]   <= '0;
                vel_reg[i]   <= '0;
                force_reg[i] <= '0;
                imp_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
                inv_mass_reg <= cfg_wdata;

            // wait counter for the shared multiplier
            if ((state_reg == ST_MUL_A || state_reg == ST_MUL_B ||
                 state_reg == ST_MUL_C || state_reg == ST_MUL_D) && !mul_done)
                cnt_reg <= cnt_reg + 2'd1;
            else
                cnt_reg <= 2'd0;

            if (in_take)
            begin
                axis_reg <= 1'b0;
                case (mode)
                    MODE_FORCE:
                    begin
                        // infinite mass drops forces
                        if (inv_mass_reg != 32'd0)
                        begin
                            force_reg[0] <= sat_add32(force_reg[0], vec_x);
                            force_reg[1] <= sat_add32(force_reg[1], vec_y);
                        end
                    end
                    MODE_IMPULSE:
                    begin
                        imp_reg[0] <= sat_add32(imp_reg[0], vec_x);
                        imp_reg[1] <= sat_add32(imp_reg[1], vec_y);
                    end
                    MODE_SET_POS:
                    begin
                        pos_reg[0] <= vec_x;
                        pos_reg[1] <= vec_y;
                    end
                    MODE_SET_VEL:
                    begin
                        vel_reg[0] <= vec_x;
                        vel_reg[1] <= vec_y;
                    end
                    default:
                    begin
                        // tick: handled by the sequencer; unused modes: no change
                    end
                endcase
            end

            if (state_reg == ST_MUL_D && mul_done)
            begin
                pos_reg[axis_reg] <= sat_add32(pos_reg[axis_reg], mul_res);
                vel_reg[axis_reg] <= sat_add32(vel_reg[axis_reg], dv_reg);
                axis_reg          <= 1'b1;
                if (axis_reg)
                begin
                    for (int i = 0; i < 2; i++)
                    begin
                        force_reg[i] <= '0;
                        imp_reg[i]   <= '0;
                    end
                end
            end

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
            dt_reg <= step_time;

        if ((state_reg == ST_MUL_A || state_reg == ST_MUL_B) && mul_done)
            tmp_reg <= mul_res;
        else if (state_reg == ST_AVG)
            tmp_reg <= sat_add32(vel_reg[axis_reg], dv_reg >>> 1);

        if (state_reg == ST_MUL_C && mul_done)
            dv_reg <= sat_add32(tmp_reg, mul_res);

        if (load_out)
        begin
            out_px_reg <= pos_reg[0];
            out_py_reg <= pos_reg[1];
            out_vx_reg <= vel_reg[0];
            out_vy_reg <= vel_reg[1];
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x_out = out_px_reg;
    assign pos_y_out = out_py_reg;
    assign vel_x_out = out_vx_reg;
    assign vel_y_out = out_vy_reg;

`ifndef SYNTHESIS
    // a tick with a nonzero step starts the multiply chain on the x axis
    a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && tick_go) |=> (state_reg == ST_MUL_A && !axis_reg))
        else $error("tick did not start the multiply sequence");

    // the multiplier wait counter never passes the pipeline latency
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MUL_LAT)
        else $error("multiplier wait counter overran");

    // finishing an item always presents a result
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (out_valid && state_reg == ST_IDLE))
        else $error("finished item produced no result");

    // no result appears unless the sequencer was finishing an item
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE))
        else $error("result appeared without a finished item");
`endif

endmodule
`default_nettype wire

// ===== sim/body_state_check_pkg.sv =====
// Predictor of the integrator state and checker of result items.
package body_state_check_pkg;
    import rbmi_pkg::*;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } body_state_t;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
    } axis_state_t;

    class body_state_scoreboard;
        logic        [31:0] inverse_mass;
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] impulse_x;
        logic signed [31:0] impulse_y;
        body_state_t        expected_states[$];
        int                 mismatch_count;

        function new();
            inverse_mass   = 32'h0001_0000;
            position_x     = '0;
            position_y     = '0;
            velocity_x     = '0;
            velocity_y     = '0;
            force_x        = '0;
            force_y        = '0;
            impulse_x      = '0;
            impulse_y      = '0;
            mismatch_count = 0;
        endfunction

        task report(string what);
            mismatch_count++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        function void set_inverse_mass(logic [31:0] value);
            inverse_mass = value;
        endfunction

        function int pending();
            return expected_states.size();
        endfunction

        function logic signed [31:0] clamp(longint v);
            if (v > longint'(Q16_MAX))
                return Q16_MAX;
            if (v < longint'(Q16_MIN))
                return Q16_MIN;
            return v[31:0];
        endfunction

        // Q16.16 product, rounded to nearest with ties upward
        function logic signed [31:0] scaled_product(longint a, longint b);
            longint p;
            p = a * b + 64'sd32768;
            return clamp(p >>> 16);
        endfunction

        function logic signed [31:0] add_clamped(logic signed [31:0] a,
                                                 logic signed [31:0] b);
            return clamp(longint'(a) + longint'(b));
        endfunction

        // one axis of a midpoint step
        function axis_state_t advance_axis(logic signed [31:0] pos,
                                           logic signed [31:0] vel,
                                           logic signed [31:0] frc,
                                           logic signed [31:0] imp,
                                           longint dt);
            longint             im;
            logic signed [31:0] accel_part;
            logic signed [31:0] force_dv;
            logic signed [31:0] impulse_dv;
            logic signed [31:0] dv;
            logic signed [31:0] avg;
            logic signed [31:0] dx;
            axis_state_t        r;
            im         = longint'({32'h0, inverse_mass});
            accel_part = scaled_product(frc, dt);
            force_dv   = scaled_product(accel_part, im);
            impulse_dv = scaled_product(imp, im);
            dv         = add_clamped(force_dv, impulse_dv);
            avg        = clamp(longint'(vel) + (longint'(dv) >>> 1));
            dx         = scaled_product(avg, dt);
            r.pos      = add_clamped(pos, dx);
            r.vel      = add_clamped(vel, dv);
            return r;
        endfunction

        function void accept_item(logic [2:0] mode, logic signed [31:0] vx,
                                  logic signed [31:0] vy, logic [23:0] dt);
            axis_state_t ax;
            axis_state_t ay;
            body_state_t s;
            case (mode)
                MODE_FORCE:
                begin
                    if (inverse_mass != 0)
                    begin
                        force_x = add_clamped(force_x, vx);
                        force_y = add_clamped(force_y, vy);
                    end
                end
                MODE_IMPULSE:
                begin
                    impulse_x = add_clamped(impulse_x, vx);
                    impulse_y = add_clamped(impulse_y, vy);
                end
                MODE_TICK:
                begin
                    if (dt != 0)
                    begin
                        ax = advance_axis(position_x, velocity_x, force_x, impulse_x,
                                          longint'({40'h0, dt}));
                        ay = advance_axis(position_y, velocity_y, force_y, impulse_y,
                                          longint'({40'h0, dt}));
                        position_x = ax.pos;
                        velocity_x = ax.vel;
                        position_y = ay.pos;
                        velocity_y = ay.vel;
                        force_x    = '0;
                        force_y    = '0;
                        impulse_x  = '0;
                        impulse_y  = '0;
                    end
                end
                MODE_SET_POS:
                begin
                    position_x = vx;
                    position_y = vy;
                end
                MODE_SET_VEL:
                begin
                    velocity_x = vx;
                    velocity_y = vy;
                end
                default: ;
            endcase
            s.pos_x = position_x;
            s.pos_y = position_y;
            s.vel_x = velocity_x;
            s.vel_y = velocity_y;
            expected_states.push_back(s);
        endfunction

        task check_state(body_state_t got);
            body_state_t want;
            if (expected_states.size() == 0)
            begin
                report($sformatf("result pos=(%0d,%0d) vel=(%0d,%0d) with none pending",
                                 got.pos_x, got.pos_y, got.vel_x, got.vel_y));
                return;
            end
            want = expected_states.pop_front();
            if (got.pos_x !== want.pos_x)
                report($sformatf("pos_x got %0d want %0d", got.pos_x, want.pos_x));
            if (got.pos_y !== want.pos_y)
                report($sformatf("pos_y got %0d want %0d", got.pos_y, want.pos_y));
            if (got.vel_x !== want.vel_x)
                report($sformatf("vel_x got %0d want %0d", got.vel_x, want.vel_x));
            if (got.vel_y !== want.vel_y)
                report($sformatf("vel_y got %0d want %0d", got.vel_y, want.vel_y));
        endtask
    endclass

endpackage

// ===== sim/rigid_body_midpoint_integrator_unit_tb.sv =====
// Testbench top: drives items and mass settings, checks every result item.
module rigid_body_midpoint_integrator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rbmi_pkg::*;
    import body_state_check_pkg::*;

    // mode codes the block must ignore
    localparam logic [2:0]  MODE_SPARE_LO = 3'd5;
    localparam logic [2:0]  MODE_SPARE_HI = 3'd7;
    localparam int          IDLE_PERCENT  = 18;
    // receiver hold-off long enough to back the block up into its input
    localparam int          HOLD_CYCLES   = 400;
    // settle between phases for longer than a tick takes
    localparam int          SETTLE_CYCLES = 40;
    localparam int          PHASE_ITEMS   = 150;
    localparam logic [31:0] UNIT_MASS     = 32'h0001_0000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic        [31:0] cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic        [2:0]  mode;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic        [23:0] step_time;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic signed [31:0] vel_x_out;
    logic signed [31:0] vel_y_out;

    body_state_scoreboard tracker;

    // steady: neither side idles; holds_wanted/holds_done hand a long
    // output hold-off request to the receiver process
    bit steady;
    int holds_wanted;
    int holds_done;

    rigid_body_midpoint_integrator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .step_time (step_time),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pos_x_out (pos_x_out),
        .pos_y_out (pos_y_out),
        .vel_x_out (vel_x_out),
        .vel_y_out (vel_y_out)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. All drives happen right after a rising edge with
    // nonblocking assignments; handshakes are sampled at the edge, which
    // sees the values from before the edge.
    // ------------------------------------------------------------------

    // Mostly small values so the state stays in range and the rounding
    // paths get exercised; extremes and full-range values mixed in.
    function automatic logic signed [31:0] random_q16();
        case ($urandom_range(0, 9))
            0:       return Q16_MAX;
            1:       return Q16_MIN;
            2, 3:    return $urandom();
            default: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
        endcase
    endfunction

    // zero steps now and then, mostly up to one second, some full range
    function automatic logic [23:0] random_step();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return 24'hFF_FFFF;
            2, 3:    return 24'($urandom());
            default: return 24'($urandom_range(1, 32'h0001_0000));
        endcase
    endfunction

    // sender gap: roughly one cycle in five is skipped unless steady
    task automatic idle_gap();
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // offer one item and hold it until taken; in_valid stays high for
    // back-to-back items so it is never dropped and re-raised in one step
    task automatic send_item(logic [2:0] m, logic signed [31:0] x,
                             logic signed [31:0] y, logic [23:0] dt);
        idle_gap();
        in_valid  <= 1'b1;
        mode      <= m;
        vec_x     <= x;
        vec_y     <= y;
        step_time <= dt;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        tracker.accept_item(m, x, y, dt);
    endtask

    // stop offering, let every expected result drain, then let the
    // sequencer settle before the mass register may be touched
    task automatic drain_block();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_inverse_mass(logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tracker.set_inverse_mass(value);
    endtask

    // Random traffic. Most of it is physics-loop shaped: a few forces and
    // impulses, maybe a set, then a tick. The rest is single items of any
    // mode, the unused codes included.
    task automatic random_traffic(int count);
        int          sent;
        int          burst;
        int          pick;
        logic [2:0]  m;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                burst = $urandom_range(1, 4);
                repeat (burst)
                begin
                    m = $urandom_range(0, 1) ? MODE_FORCE : MODE_IMPULSE;
                    send_item(m, random_q16(), random_q16(), 24'($urandom()));
                    sent++;
                end
                if ($urandom_range(0, 7) == 0)
                begin
                    m = $urandom_range(0, 1) ? MODE_SET_POS : MODE_SET_VEL;
                    send_item(m, random_q16(), random_q16(), 24'($urandom()));
                    sent++;
                end
                send_item(MODE_TICK, $urandom(), $urandom(), random_step());
                sent++;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 25)
                    m = MODE_FORCE;
                else if (pick < 45)
                    m = MODE_IMPULSE;
                else if (pick < 70)
                    m = MODE_TICK;
                else if (pick < 82)
                    m = MODE_SET_POS;
                else if (pick < 94)
                    m = MODE_SET_VEL;
                else
                    m = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
                send_item(m, random_q16(), random_q16(),
                          (m == MODE_TICK) ? random_step() : 24'($urandom()));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random output stalls, plus long hold-offs on request. The
    // hold is counted here so the sender keeps pushing while it lasts.
    // ------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_done != holds_wanted)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // every taken result item goes to the checker
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            tracker.check_state(body_state_t'{pos_x_out, pos_y_out,
                                              vel_x_out, vel_y_out});
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #2_000_000;
        $display("[rigid_body_midpoint_integrator_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        tracker      = new();
        steady       = 1'b0;
        holds_wanted = 0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        mode         = MODE_FORCE;
        vec_x        = '0;
        vec_y        = '0;
        step_time    = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, mass at its reset value of 1.0.
        // tick on a body at rest; vec fields are ignored in ticks
        send_item(MODE_TICK, 32'sh1234_5678, -32'sh0765_4321, 24'h00_0001);
        // extremes of position, step_time ignored outside ticks
        send_item(MODE_SET_POS, Q16_MAX, Q16_MIN, 24'hFF_FFFF);
        send_item(MODE_SET_VEL, 32'sh0001_0000, -32'sh0001_0000, 24'hAA_5555);
        // position clamps at both rails
        send_item(MODE_TICK, '0, '0, 24'h01_0000);
        // force and impulse accumulators clamp
        send_item(MODE_FORCE, Q16_MAX, Q16_MIN, '0);
        send_item(MODE_FORCE, Q16_MAX, Q16_MIN, '0);
        send_item(MODE_IMPULSE, Q16_MIN, Q16_MAX, '0);
        send_item(MODE_IMPULSE, Q16_MIN, Q16_MAX, '0);
        // zero step keeps everything, accumulators too
        send_item(MODE_TICK, Q16_MAX, Q16_MAX, '0);
        // longest step with everything saturated
        send_item(MODE_TICK, '0, '0, 24'hFF_FFFF);
        // unused codes change nothing
        send_item(MODE_SPARE_LO, Q16_MAX, Q16_MIN, 24'hFF_FFFF);
        send_item(3'(MODE_SPARE_LO + 3'd1), -32'sd1, 32'sd1, 24'h00_0001);
        send_item(MODE_SPARE_HI, Q16_MIN, Q16_MAX, 24'h80_0000);
        send_item(MODE_SET_POS, '0, '0, '0);
        send_item(MODE_SET_VEL, '0, '0, '0);
        // half-second step, rounding of small products
        send_item(MODE_FORCE, 32'sh0003_0000, -32'sh0002_0000, '0);
        send_item(MODE_IMPULSE, 32'sh0000_8000, -32'sd1, '0);
        send_item(MODE_TICK, '0, '0, 24'h00_8000);
        // odd dv and negative velocity: halving floors, products round
        send_item(MODE_SET_VEL, -32'sd1, 32'sd1, '0);
        send_item(MODE_IMPULSE, 32'sd3, -32'sd3, '0);
        send_item(MODE_TICK, '0, '0, 24'h00_0001);
        // random part; the receiver holds off once to fill the block
        holds_wanted++;
        random_traffic(PHASE_ITEMS);
        drain_block();

        // Infinite mass: forces dropped, impulses accumulate but do nothing
        write_inverse_mass('0);
        send_item(MODE_SET_VEL, 32'sh0002_0000, -32'sh0001_8000, '0);
        send_item(MODE_FORCE, 32'sh0005_0000, 32'sh0005_0000, '0);
        send_item(MODE_IMPULSE, 32'sh0001_0000, Q16_MIN, '0);
        send_item(MODE_TICK, '0, '0, 24'h01_0000);
        random_traffic(PHASE_ITEMS);
        drain_block();

        // Largest inverse mass, both sides running flat out, second hold
        write_inverse_mass(32'hFFFF_FFFF);
        steady = 1'b1;
        holds_wanted++;
        random_traffic(PHASE_ITEMS);
        drain_block();
        steady = 1'b0;

        // Smallest nonzero inverse mass
        write_inverse_mass(32'h0000_0001);
        random_traffic(PHASE_ITEMS);
        drain_block();

        // Arbitrary mass, then back to 1.0
        write_inverse_mass($urandom());
        random_traffic(PHASE_ITEMS / 2);
        drain_block();
        write_inverse_mass(UNIT_MASS);
        random_traffic(PHASE_ITEMS / 2);
        drain_block();

        if (tracker.mismatch_count == 0 && tracker.pending() == 0)
            $display("[rigid_body_midpoint_integrator_unit] OK");
        else
            $display("[rigid_body_midpoint_integrator_unit] ERROR");
        $finish;
    end

endmodule
